// File: hdl/bcps_pkg.sv
// ----------------------------------------------------------------------------
// Best-candidate sampler package
// Shared widths, register indexes and payload types of the point sampler.
// ----------------------------------------------------------------------------
package bcps_pkg;

	localparam int COORD_BITS  = 24;
	localparam int DIST_W      = 50;
	localparam int GROUP_W     = 7;
	localparam int POINT_IDX_W = 12;
	localparam int CFG_DATA_W  = 50;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// configuration register indexes
	localparam logic REG_GROUP_SIZE = 1'b0;
	localparam logic REG_EXCL_RAD_SQ = 1'b1;

	localparam logic [GROUP_W-1:0] GROUP_SIZE_RST = 7'd50;
	localparam logic [DIST_W-1:0]  EXCL_RAD_SQ_RST = 50'd72958313963;

	// input actions
	localparam logic ACT_LOAD      = 1'b0;
	localparam logic ACT_CANDIDATE = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic   action;
		coord_t x_pos;
		coord_t y_pos;
	} item_t;

	typedef struct packed {
		coord_t                 chosen_x;
		coord_t                 chosen_y;
		logic [POINT_IDX_W-1:0] point_index;
		logic                   store_full;
	} result_t;

endpackage

// File: hdl/best_candidate_point_sampler_unit.sv
// ----------------------------------------------------------------------------
// Best-candidate point sampler
// Point store in one synchronous RAM; each candidate outside the exclusion radius
// is scanned for its nearest stored point; the best of a group is appended if room.
// ----------------------------------------------------------------------------
// The RAM read port visits one point per cycle. Load: appended to the store, or
// a refusal emitted when full. Candidate: origin check (a rejected one ends there),
// scan (none if empty), drain, decide; a group's end emits its best, refused if full.
// One item is in work at a time; emit waits while the output register is occupied.
// Reset clears the point count, group state and result valid flag, and loads
// the configuration defaults; the RAM contents are left as they are.
module best_candidate_point_sampler_unit
	import bcps_pkg::*;
#(
	parameter int STORE_DEPTH = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_BITS = $clog2(STORE_DEPTH);
	localparam int CNT_BITS = IDX_BITS + 1;
	localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(STORE_DEPTH);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_ORIG   = 3'd1;
	localparam logic [2:0] ST_OWAIT  = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_DRAIN  = 3'd4;
	localparam logic [2:0] ST_DECIDE = 3'd5;
	localparam logic [2:0] ST_EMIT   = 3'd6;

	logic [2:0]              state_q;
	logic [GROUP_W-1:0]      group_size_q;
	logic [DIST_W-1:0]       excl_q;
	logic [CNT_BITS-1:0]     count_q;
	logic [GROUP_W-1:0]      acc_q;
	coord_t                  best_x_q, best_y_q;
	logic [DIST_W-1:0]       best_min_q;
	coord_t                  cand_x_q, cand_y_q;
	logic [DIST_W-1:0]       min_q;
	logic [IDX_BITS-1:0]     ptr_q;
	result_t                 res_q;
	result_t                 out_q;
	logic                    out_valid_q;

	// point store
	logic [2*COORD_BITS-1:0] mem [STORE_DEPTH];
	logic [2*COORD_BITS-1:0] rd_q;
	logic                    mem_we;
	logic [IDX_BITS-1:0]     mem_waddr;
	logic [2*COORD_BITS-1:0] mem_wdata;

	// distance pipeline
	logic                    issue;
	logic                    issue_orig;
	logic                    issue_last;
	logic                    vld_s1, orig_s1, last_s1;
	logic                    vld_s2, orig_s2, last_s2;
	logic [2*COORD_BITS-1:0] sqx_s2, sqy_s2;
	coord_t                  px, py;
	logic [COORD_BITS:0]     dx, dy;
	logic [COORD_BITS-1:0]   ax, ay;
	logic [DIST_W:0]         sum;
	logic [DIST_W-1:0]       pt_dist;

	// decision
	logic                    has_room;
	logic                    take_cand;
	logic [GROUP_W-1:0]      acc_n;
	logic                    grp_done;
	coord_t                  win_x, win_y;
	logic [31:0]             cnt_ext;
	logic                    accept;
	logic                    out_free;

	assign accept     = item_valid && item_ready;
	assign item_ready = (state_q == ST_IDLE);
	assign has_room   = (count_q < DEPTH_CNT);
	assign out_free   = !out_valid_q || result_ready;
	assign cnt_ext    = 32'(count_q);

	assign take_cand = (acc_q == '0) || (best_min_q < min_q);
	assign acc_n     = acc_q + GROUP_W'(1);
	assign grp_done  = (acc_n == '0) || (acc_n >= group_size_q);
	assign win_x     = take_cand ? cand_x_q : best_x_q;
	assign win_y     = take_cand ? cand_y_q : best_y_q;

	assign issue      = (state_q == ST_ORIG) || (state_q == ST_SCAN);
	assign issue_orig = (state_q == ST_ORIG);
	assign issue_last = (state_q == ST_SCAN) &&
		({1'b0, ptr_q} == count_q - CNT_BITS'(1));

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[IDX_BITS-1:0];
		mem_wdata = {item.x_pos, item.y_pos};
		if (accept && item.action == ACT_LOAD && has_room) begin
			mem_we = 1'b1;
		end else if (state_q == ST_DECIDE && grp_done && has_room) begin
			mem_we    = 1'b1;
			mem_wdata = {win_x, win_y};
		end
	end

	// Scan reads and writes never overlap: writes happen only outside the scan.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[ptr_q];
	end

	// stage 1: difference and square of each axis
	always_comb begin
		px = orig_s1 ? coord_t'(0) : coord_t'(rd_q[2*COORD_BITS-1:COORD_BITS]);
		py = orig_s1 ? coord_t'(0) : coord_t'(rd_q[COORD_BITS-1:0]);
		dx = {cand_x_q[COORD_BITS-1], cand_x_q} - {px[COORD_BITS-1], px};
		dy = {cand_y_q[COORD_BITS-1], cand_y_q} - {py[COORD_BITS-1], py};
		ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
		ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		sqx_s2 <= ax * ax;
		sqy_s2 <= ay * ay;
	end

	// stage 2: saturating sum
	always_comb begin
		sum     = (DIST_W+1)'(sqx_s2) + (DIST_W+1)'(sqy_s2);
		pt_dist = (sum > (DIST_W+1)'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			orig_s1 <= 1'b0;
			orig_s2 <= 1'b0;
			last_s1 <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s1  <= issue;
			orig_s1 <= issue_orig;
			last_s1 <= issue_last;
			vld_s2  <= vld_s1;
			orig_s2 <= orig_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= GROUP_SIZE_RST;
			excl_q       <= EXCL_RAD_SQ_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GROUP_SIZE:  group_size_q <= cfg_data[GROUP_W-1:0];
				REG_EXCL_RAD_SQ: excl_q       <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			acc_q       <= '0;
			best_x_q    <= '0;
			best_y_q    <= '0;
			best_min_q  <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one is loaded now
			if (out_valid_q && result_ready && !(state_q == ST_EMIT && out_free)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.action == ACT_CANDIDATE) begin
							state_q <= ST_ORIG;
						end else if (has_room) begin
							count_q <= count_q + CNT_BITS'(1);
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_ORIG: begin
					state_q <= ST_OWAIT;
				end
				ST_OWAIT: begin
					if (vld_s2) begin
						ptr_q <= '0;
						if (pt_dist < excl_q) begin
							state_q <= ST_IDLE;
						end else if (count_q == '0) begin
							state_q <= ST_DECIDE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					ptr_q <= ptr_q + IDX_BITS'(1);
					if (issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (vld_s2 && last_s2) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (grp_done) begin
						acc_q      <= '0;
						best_x_q   <= '0;
						best_y_q   <= '0;
						best_min_q <= '0;
						if (has_room) begin
							count_q <= count_q + CNT_BITS'(1);
						end
						state_q <= ST_EMIT;
					end else begin
						acc_q <= acc_n;
						if (take_cand) begin
							best_x_q   <= cand_x_q;
							best_y_q   <= cand_y_q;
							best_min_q <= min_q;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cand_x_q <= item.x_pos;
			cand_y_q <= item.y_pos;
			res_q    <= '{chosen_x: item.x_pos, chosen_y: item.y_pos,
				point_index: '0, store_full: 1'b1};
		end
		// seed the minimum once the origin check is through, then track it
		if (state_q == ST_OWAIT) begin
			min_q <= DIST_MAX;
		end else if (vld_s2 && !orig_s2 && pt_dist < min_q) begin
			min_q <= pt_dist;
		end
		if (state_q == ST_DECIDE) begin
			res_q.chosen_x    <= win_x;
			res_q.chosen_y    <= win_y;
			res_q.point_index <= has_room ? cnt_ext[POINT_IDX_W-1:0] : '0;
			res_q.store_full  <= !has_room;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_q <= res_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT)
		else $error("point count beyond store depth");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ({1'b0, ptr_q} < count_q))
		else $error("scan reads beyond stored points");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_IDLE || state_q == ST_DECIDE))
		else $error("store written while a scan may be in flight");

	a_group_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && grp_done) |=> (state_q == ST_EMIT))
		else $error("finished group did not move to emit");

	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && vld_s2 && last_s2) |=> (state_q == ST_DECIDE))
		else $error("last distance did not end the scan");

endmodule

// File: sim/best_candidate_point_sampler_unit_tb.sv
// ----------------------------------------------------------------------------
// Best-candidate point sampler testbench
// Drives load and candidate items through the valid/ready input channel.
// Each transfer is mirrored in a behavioral copy of the point store and the
// group logic, and every emitted point is compared field by field. A short
// directed table comes first, then random phases under several register
// settings.
// ----------------------------------------------------------------------------
module best_candidate_point_sampler_unit_tb;
	import bcps_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = 4096;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam coord_t C_MAX = 24'sh7FFFFF;
	localparam coord_t C_MIN = 24'sh800000;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_ready;
	item_t                 item;
	logic                  result_valid;
	logic                  result_ready;
	result_t               result;
	logic                  cfg_we;
	logic                  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	best_candidate_point_sampler_unit #(
		.STORE_DEPTH(STORE_DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	typedef struct {
		bit                    is_cfg;
		logic                  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		item_t                 pt;
		bit                    typed;
		bit                    want;
		result_t               exp;
	} step_row_t;

	// behavioral copy of the sampler
	coord_t             pts_x [STORE_DEPTH];
	coord_t             pts_y [STORE_DEPTH];
	int                 pts_n;
	logic [GROUP_W-1:0] grp_taken;
	coord_t             lead_x;
	coord_t             lead_y;
	logic [DIST_W-1:0]  lead_gap;
	logic [GROUP_W-1:0] grp_size;
	logic [DIST_W-1:0]  excl_r2;

	result_t pending_points[$];
	step_row_t steps[$];

	int idle_pct;
	int n_loads, n_cands, n_results, n_errors, n_settings, n_full;
	int stall_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void add_step(step_row_t s);
		steps.insert(steps.size(), s);
	endfunction

	function automatic void expect_point(result_t r);
		pending_points.insert(pending_points.size(), r);
	endfunction

	function automatic result_t make_result(coord_t x, coord_t y, int idx, bit full);
		result_t r;
		r.chosen_x    = x;
		r.chosen_y    = y;
		r.point_index = POINT_IDX_W'(idx);
		r.store_full  = full;
		return r;
	endfunction

	function automatic step_row_t cfg_row(logic idx, logic [CFG_DATA_W-1:0] val);
		step_row_t s;
		s = '{default: '0};
		s.is_cfg  = 1'b1;
		s.reg_idx = idx;
		s.reg_val = val;
		return s;
	endfunction

	function automatic step_row_t pt_row(logic act, coord_t x, coord_t y);
		step_row_t s;
		s = '{default: '0};
		s.pt.action = act;
		s.pt.x_pos  = x;
		s.pt.y_pos  = y;
		return s;
	endfunction

	function automatic step_row_t typed_row(logic act, coord_t x, coord_t y, bit want,
			result_t exp);
		step_row_t s;
		s = pt_row(act, x, y);
		s.typed = 1'b1;
		s.want  = want;
		s.exp   = exp;
		return s;
	endfunction

	function automatic logic [DIST_W-1:0] sq_dist(coord_t ax, coord_t ay, coord_t bx,
			coord_t by);
		longint dx, dy;
		longint unsigned s;
		dx = longint'(ax) - longint'(bx);
		dy = longint'(ay) - longint'(by);
		s = longint'(dx * dx) + longint'(dy * dy);
		if (s > DIST_MAX)
			return DIST_MAX;
		return s[DIST_W-1:0];
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(3))
			0: return coord_t'($urandom);
			1: return coord_t'(int'($urandom_range(2000)) - 1000);
			2: begin
				case ($urandom_range(2))
					0: return C_MIN;
					1: return C_MAX;
					default: return '0;
				endcase
			end
			default: return coord_t'(int'($urandom_range(2 ** 21)) - 2 ** 20);
		endcase
	endfunction

	// Update the store copy for one transfer; got is set when a point comes out.
	task automatic pick_best_candidate(input item_t pt, output bit got, output result_t res);
		logic [DIST_W-1:0] nearest, d;
		got = 1'b0;
		res = '0;
		if (pt.action == ACT_LOAD) begin
			if (pts_n < STORE_DEPTH) begin
				pts_x[pts_n] = pt.x_pos;
				pts_y[pts_n] = pt.y_pos;
				pts_n++;
			end else begin
				got = 1'b1;
				res = make_result(pt.x_pos, pt.y_pos, 0, 1'b1);
			end
			return;
		end
		if (sq_dist(pt.x_pos, pt.y_pos, '0, '0) < excl_r2)
			return;
		nearest = DIST_MAX;
		for (int i = 0; i < pts_n; i++) begin
			d = sq_dist(pt.x_pos, pt.y_pos, pts_x[i], pts_y[i]);
			if (d < nearest)
				nearest = d;
		end
		// first of a group always leads; later ones need a strictly larger gap
		if (grp_taken == '0 || lead_gap < nearest) begin
			lead_gap = nearest;
			lead_x   = pt.x_pos;
			lead_y   = pt.y_pos;
		end
		grp_taken = grp_taken + 1'b1;
		if (grp_taken != '0 && grp_taken < grp_size)
			return;
		got = 1'b1;
		if (pts_n < STORE_DEPTH) begin
			res = make_result(lead_x, lead_y, pts_n, 1'b0);
			pts_x[pts_n] = lead_x;
			pts_y[pts_n] = lead_y;
			pts_n++;
		end else begin
			res = make_result(lead_x, lead_y, 0, 1'b1);
		end
		grp_taken = '0;
		lead_x    = '0;
		lead_y    = '0;
		lead_gap  = '0;
	endtask

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic push_item(input item_t pt, input bit typed, input bit want,
			input result_t typed_res);
		bit got;
		result_t res;
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item       <= pt;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		pick_best_candidate(pt, got, res);
		if (typed) begin
			if (want)
				expect_point(typed_res);
		end else if (got) begin
			expect_point(res);
		end
		if (pt.action == ACT_LOAD)
			n_loads++;
		else
			n_cands++;
		@(negedge clk);
	endtask

	task automatic set_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
		item_valid <= 1'b0;
		while (pending_points.size() != 0)
			@(negedge clk);
		// let a scan that produces no point run out
		repeat (pts_n + 32) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_GROUP_SIZE)
			grp_size = val[GROUP_W-1:0];
		else
			excl_r2 = val[DIST_W-1:0];
		n_settings++;
	endtask

	task automatic run_phase(input logic [GROUP_W-1:0] gs, input logic [DIST_W-1:0] r2,
			input int n, input int cand_pct);
		item_t pt;
		set_reg(REG_GROUP_SIZE, {(CFG_DATA_W - GROUP_W)'({$urandom, $urandom}), gs});
		set_reg(REG_EXCL_RAD_SQ, r2);
		repeat (n) begin
			pt.action = ($urandom_range(99) < cand_pct) ? ACT_CANDIDATE : ACT_LOAD;
			pt.x_pos  = rand_coord();
			pt.y_pos  = rand_coord();
			push_item(pt, 1'b0, 1'b0, '0);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			n_results++;
			if (result.store_full)
				n_full++;
			if (pending_points.size() == 0) begin
				$display("%0t: unexpected point x=%0d y=%0d idx=%0d full=%0d", $time,
					result.chosen_x, result.chosen_y, result.point_index, result.store_full);
				n_errors++;
			end else begin
				want = pending_points.pop_front();
				if (result.chosen_x !== want.chosen_x) begin
					$display("%0t: chosen_x expected %0d actual %0d", $time,
						want.chosen_x, result.chosen_x);
					n_errors++;
				end
				if (result.chosen_y !== want.chosen_y) begin
					$display("%0t: chosen_y expected %0d actual %0d", $time,
						want.chosen_y, result.chosen_y);
					n_errors++;
				end
				if (result.point_index !== want.point_index) begin
					$display("%0t: point_index expected %0d actual %0d", $time,
						want.point_index, result.point_index);
					n_errors++;
				end
				if (result.store_full !== want.store_full) begin
					$display("%0t: store_full expected %0d actual %0d", $time,
						want.store_full, result.store_full);
					n_errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, stall_cycles);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// output side: random back-pressure plus one long hold-off
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && n_results >= 12) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				result_ready <= 1'b0;
				hold_left--;
			end else begin
				result_ready <= (arst_n && $urandom_range(99) >= idle_pct);
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		cfg_we     = 1'b0;
		cfg_index  = REG_GROUP_SIZE;
		cfg_data   = '0;
		idle_pct   = 28;
		pts_n      = 0;
		grp_taken  = '0;
		lead_x     = '0;
		lead_y     = '0;
		lead_gap   = '0;
		grp_size   = GROUP_SIZE_RST;
		excl_r2    = EXCL_RAD_SQ_RST;
		n_loads = 0; n_cands = 0; n_results = 0; n_errors = 0; n_settings = 0; n_full = 0;
		stall_cycles = 0;

		// reset radius: just inside rejects, just outside starts a group
		add_step(typed_row(ACT_CANDIDATE, 0, 0, 0, '0));
		add_step(typed_row(ACT_CANDIDATE, 270000, 0, 0, '0));
		add_step(typed_row(ACT_CANDIDATE, 270108, 0, 0, '0));
		add_step(cfg_row(REG_GROUP_SIZE, 1));
		add_step(cfg_row(REG_EXCL_RAD_SQ, 0));
		// equal gaps on an empty store: the earlier candidate wins
		add_step(typed_row(ACT_CANDIDATE, C_MAX, C_MAX, 1,
			make_result(270108, 0, 0, 0)));
		add_step(typed_row(ACT_CANDIDATE, C_MIN, C_MIN, 1,
			make_result(C_MIN, C_MIN, 1, 0)));
		add_step(typed_row(ACT_LOAD, C_MAX, C_MIN, 0, '0));
		add_step(typed_row(ACT_LOAD, 0, 0, 0, '0));
		add_step(typed_row(ACT_CANDIDATE, C_MIN, C_MAX, 1,
			make_result(C_MIN, C_MAX, 4, 0)));
		add_step(cfg_row(REG_GROUP_SIZE, 2));
		add_step(pt_row(ACT_CANDIDATE, 100, 0));
		add_step(typed_row(ACT_CANDIDATE, -100, 0, 1, make_result(100, 0, 5, 0)));
		add_step(pt_row(ACT_CANDIDATE, 0, 50));
		add_step(pt_row(ACT_CANDIDATE, 0, 5000));
		// widest radius rejects every candidate
		add_step(cfg_row(REG_EXCL_RAD_SQ, DIST_MAX));
		add_step(typed_row(ACT_CANDIDATE, C_MIN, C_MIN, 0, '0));
		add_step(typed_row(ACT_LOAD, -1, -1, 0, '0));
		add_step(cfg_row(REG_GROUP_SIZE, 0));
		add_step(cfg_row(REG_EXCL_RAD_SQ, 0));
		add_step(pt_row(ACT_CANDIDATE, 1, 1));
		add_step(pt_row(ACT_LOAD, C_MIN, C_MAX));

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (steps[i]) begin
			if (steps[i].is_cfg)
				set_reg(steps[i].reg_idx, steps[i].reg_val);
			else
				push_item(steps[i].pt, steps[i].typed, steps[i].want, steps[i].exp);
		end

		run_phase(7'd1, '0, 20, 75);
		run_phase(7'd2, DIST_W'($urandom) << 14, 20, 70);
		run_phase(7'd127, DIST_MAX, 10, 60);
		idle_pct = 0;
		run_phase(7'd0, '0, 15, 70);
		idle_pct = 28;
		run_phase(7'd64, '0, 50, 95);
		run_phase(GROUP_SIZE_RST, EXCL_RAD_SQ_RST, 15, 80);
		item_valid <= 1'b0;

		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (pts_n + 40) @(posedge clk);

		$display("Sent %0d loads and %0d candidates under %0d register writes.",
			n_loads, n_cands, n_settings);
		$display("Checked %0d emitted points (%0d refused by a full store), %0d stored.",
			n_results, n_full, pts_n);
		if (n_errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: sim.f
hdl/bcps_pkg.sv
hdl/best_candidate_point_sampler_unit.sv
sim/best_candidate_point_sampler_unit_tb.sv
